### rtl/core/ngtl_pkg.sv
// ----------------------------------------------------------------------------
// ngtl_pkg
// Types and constants shared by the nearest grid table lookup core.
// ----------------------------------------------------------------------------
package ngtl_pkg;

   localparam logic [1:0] OP_LOAD_GRID  = 2'd0;
   localparam logic [1:0] OP_LOAD_TABLE = 2'd1;
   localparam logic [1:0] OP_QUERY      = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DOMAIN   = 2'd1;
   localparam logic [1:0] ST_COUNT    = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [2:0] REG_DIMS  = 3'd0;
   localparam logic [2:0] REG_SIZE0 = 3'd1;
   localparam logic [2:0] REG_SIZE1 = 3'd2;
   localparam logic [2:0] REG_SIZE2 = 3'd3;
   localparam logic [2:0] REG_SIZE3 = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;    // latch the accepted item
      logic grid_write;   // write grid memory from latched item
      logic table_write;  // write table memory from latched item
      logic search_init;  // set up a query coordinate
      logic rd_first;     // read first grid point
      logic rd_last;      // read last grid point
      logic rd_mid;       // read the candidate grid point
      logic cap_first;    // capture first point
      logic cap_last;     // capture last point, check domain
      logic step;         // test the candidate point against x
      logic rd_low;       // read the point below the found one
      logic pick;         // choose neighbor and update index
      logic skip;         // count coordinate without evaluation
      logic rd_table;     // read table value for result
      logic finish;       // build result and clear query
   } ngtl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_grid;
      logic is_table;
      logic is_query;
      logic eval;        // coordinate must be evaluated
      logic last;        // item ends the query
      logic dom_err;     // domain check failed
      logic search_done; // first point above x found
      logic res_ok;      // result needs the table read
   } ngtl_sts_type;

endpackage

### rtl/core/ngtl_ram.sv
// ----------------------------------------------------------------------------
// ngtl_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ngtl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/ngtl_ctrl.sv
// ----------------------------------------------------------------------------
// ngtl_ctrl
// Sequencer for loads, the per-coordinate grid scan and the result.
// ----------------------------------------------------------------------------
module ngtl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ngtl_pkg::ngtl_cmd_type cmd,
   input  ngtl_pkg::ngtl_sts_type sts
);
   import ngtl_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_RDF   = 4'd2;
   localparam logic [3:0] S_RDL   = 4'd3;
   localparam logic [3:0] S_CAPL  = 4'd5;
   localparam logic [3:0] S_SRCH  = 4'd6;
   localparam logic [3:0] S_WAIT  = 4'd7;
   localparam logic [3:0] S_LOW   = 4'd8;
   localparam logic [3:0] S_LOWW  = 4'd9;
   localparam logic [3:0] S_PICK  = 4'd10;
   localparam logic [3:0] S_END   = 4'd11;
   localparam logic [3:0] S_TAB   = 4'd12;
   localparam logic [3:0] S_TABW  = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            priority if (sts.is_grid) begin
               cmd.grid_write = 1'b1;
               state_in = S_IDLE;
            end else if (sts.is_table) begin
               cmd.table_write = 1'b1;
               state_in = S_IDLE;
            end else if (sts.is_query && sts.eval) begin
               cmd.search_init = 1'b1;
               state_in = S_RDF;
            end else if (sts.is_query) begin
               cmd.skip = 1'b1;
               state_in = S_END;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RDF: begin
            cmd.rd_first = 1'b1;
            state_in = S_RDL;
         end
         S_RDL: begin
            // The first point arrives while the last one is requested.
            cmd.rd_last   = 1'b1;
            cmd.cap_first = 1'b1;
            state_in = S_CAPL;
         end
         S_CAPL: begin
            cmd.cap_last = 1'b1;
            state_in = S_SRCH;
         end
         S_SRCH: begin
            if (sts.dom_err) begin
               state_in = S_END;
            end else if (sts.search_done) begin
               cmd.rd_low = 1'b1;
               state_in = S_LOWW;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_LOW;
         end
         S_LOW: begin
            cmd.step = 1'b1;
            state_in = S_SRCH;
         end
         S_LOWW: begin
            // Hold the address so the lower point is still on the read port.
            cmd.rd_low = 1'b1;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_END;
         end
         S_END: begin
            if (!sts.last) begin
               state_in = S_IDLE;
            end else if (sts.res_ok) begin
               cmd.rd_table = 1'b1;
               state_in = S_TABW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_TABW: begin
            state_in = S_TAB;
         end
         S_TAB: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

### rtl/core/ngtl_dp.sv
// ----------------------------------------------------------------------------
// ngtl_dp
// Datapath: item latch, grid and table memories, candidate scan, index.
// ----------------------------------------------------------------------------
module ngtl_dp #(
   parameter int MAX_DIMS    = 4,
   parameter int GRID_DEPTH  = 256,
   parameter int TABLE_DEPTH = 4096,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ngtl_pkg::ngtl_cmd_type cmd,
   output ngtl_pkg::ngtl_sts_type sts,
   input  logic [2:0]             dims_in_use,
   input  logic [8:0]             grid_size [4],
   input  logic [1:0]             req_operation,
   input  logic [1:0]             req_dim_select,
   input  logic [11:0]            req_position,
   input  logic signed [31:0]     req_data_value,
   input  logic                   req_last_coord,
   output logic signed [31:0]     rsp_table_value,
   output logic [1:0]             rsp_status,
   output logic [11:0]            rsp_flat_index
);
   import ngtl_pkg::*;

   localparam int GW  = $clog2(GRID_DEPTH);
   localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int GAW = $clog2(MAX_DIMS * GRID_DEPTH);
   localparam int TW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(MAX_DIMS + 1);
   localparam int NW  = GW + 1;

   logic [1:0]         op_ff;
   logic [1:0]         dsel_ff;
   logic [11:0]        pos_ff;
   logic signed [31:0] data_ff;
   logic               last_ff;

   logic [CW-1:0]  count_ff;
   logic [TW-1:0]  pidx_ff;
   logic [1:0]     qerr_ff;

   logic [NW-1:0]  hi_ff;          // candidate index of the scan
   logic           found_ff;
   logic [NW-1:0]  size_ff;
   logic [DW-1:0]  dim_ff;
   logic signed [31:0] gfirst_ff, ghigh_ff;
   logic           dom_ff;

   logic [1:0]     st_ff;
   logic [TW-1:0]  idx_ff;
   logic [31:0]    val_ff;

   // Effective dimension count and size.
   logic [CW-1:0] dims_eff;
   logic [NW-1:0] size_eff;
   logic [8:0]    size_raw;

   always_comb begin
      if (dims_in_use == 3'd0) begin
         dims_eff = CW'(1);
      end else if (32'(dims_in_use) > MAX_DIMS) begin
         dims_eff = CW'(MAX_DIMS);
      end else begin
         dims_eff = CW'(dims_in_use);
      end
      size_raw = (32'(count_ff) < 4) ? grid_size[count_ff[1:0]] : 9'd1;
      if (size_raw == 9'd0) begin
         size_eff = NW'(1);
      end else if (32'(size_raw) > GRID_DEPTH) begin
         size_eff = NW'(GRID_DEPTH);
      end else begin
         size_eff = NW'(size_raw);
      end
   end

   // Grid memory.
   logic [GAW-1:0] gaddr;
   logic [NW-1:0]  gidx;
   logic           gwe;
   logic [31:0]    grd;
   logic [DW-1:0]  gdim;

   always_comb begin
      gwe  = cmd.grid_write && (32'(dsel_ff) < MAX_DIMS) && (32'(pos_ff) < GRID_DEPTH);
      gdim = cmd.grid_write ? DW'(dsel_ff) : dim_ff;
      priority if (cmd.grid_write) gidx = NW'(pos_ff);
      else if (cmd.rd_first)       gidx = '0;
      else if (cmd.rd_last)        gidx = size_ff - NW'(1);
      else if (cmd.rd_low)         gidx = hi_ff - NW'(1);
      else                         gidx = hi_ff;
      gaddr = GAW'(32'(gdim) * GRID_DEPTH + 32'(gidx[GW-1:0]));
   end

   ngtl_ram #(.WIDTH(32), .DEPTH(MAX_DIMS * GRID_DEPTH)) u_grid (
      .clock(clock), .wr_en(gwe), .addr(gaddr), .wr_data(data_ff), .rd_data(grd)
   );

   // Table memory.
   logic [TW-1:0]          taddr;
   logic                   twe;
   logic [VALUE_WIDTH-1:0] trd;

   assign twe   = cmd.table_write && (32'(pos_ff) < TABLE_DEPTH);
   assign taddr = cmd.table_write ? TW'(pos_ff) : pidx_ff;

   ngtl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .wr_en(twe), .addr(taddr),
      .wr_data(VALUE_WIDTH'(data_ff)), .rd_data(trd)
   );

   // Neighbor choice: the scan stops at hi, the first point above x in index order.
   logic signed [32:0] dlow, dhigh;
   logic [NW-1:0]      pick;
   logic [TW+NW-1:0]   next_idx;

   always_comb begin
      dlow     = 33'(data_ff) - 33'(signed'(grd));
      dhigh    = 33'(ghigh_ff) - 33'(data_ff);
      pick     = (dlow < dhigh) ? hi_ff - NW'(1) : hi_ff;
      next_idx = (TW+NW)'(pidx_ff) * (TW+NW)'(size_ff) + (TW+NW)'(pick);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_operation;
         dsel_ff <= req_dim_select;
         pos_ff  <= req_position;
         data_ff <= req_data_value;
         last_ff <= req_last_coord;
      end
      if (cmd.search_init) begin
         size_ff <= size_eff;
         dim_ff  <= DW'(count_ff);
      end
      if (cmd.cap_first) begin
         gfirst_ff <= signed'(grd);
      end
      if (cmd.cap_last) begin
         // Inside the domain the last point lies above x, so the scan ends.
         hi_ff    <= NW'(1);
         found_ff <= 1'b0;
         ghigh_ff <= signed'(grd);
         dom_ff   <= (data_ff < gfirst_ff) || (data_ff >= signed'(grd)) ||
                     (size_ff == NW'(1));
      end
      if (cmd.step) begin
         if (signed'(grd) > data_ff) begin
            found_ff <= 1'b1;
            ghigh_ff <= signed'(grd);
         end else begin
            hi_ff <= hi_ff + NW'(1);
         end
      end
   end

   // Query state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pidx_ff  <= '0;
         qerr_ff  <= ST_OK;
      end else begin
         if (cmd.search_init || cmd.skip) begin
            if (count_ff >= dims_eff) begin
               qerr_ff <= ST_COUNT;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.cap_last && ((data_ff < gfirst_ff) || (data_ff >= signed'(grd)) ||
                              (size_ff == NW'(1)))) begin
            qerr_ff <= ST_DOMAIN;
         end
         if (cmd.pick) begin
            if (next_idx >= (TW+NW)'(TABLE_DEPTH)) begin
               qerr_ff <= ST_OVERFLOW;
            end else begin
               pidx_ff <= TW'(next_idx);
            end
         end
         if (cmd.finish) begin
            count_ff <= '0;
            pidx_ff  <= '0;
            qerr_ff  <= ST_OK;
         end
      end
   end

   logic [1:0] final_st;
   assign final_st = ((qerr_ff == ST_COUNT) || (count_ff != dims_eff)) ? ST_COUNT : qerr_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_table) begin
         idx_ff <= pidx_ff;
      end
      if (cmd.finish) begin
         st_ff <= final_st;
         if (final_st != ST_OK) begin
            idx_ff <= '0;
            val_ff <= '0;
         end else begin
            val_ff <= 32'(signed'(trd));
         end
      end
   end

   always_comb begin
      sts.is_grid     = (op_ff == OP_LOAD_GRID);
      sts.is_table    = (op_ff == OP_LOAD_TABLE);
      sts.is_query    = (op_ff == OP_QUERY);
      sts.eval        = (count_ff < dims_eff) && (qerr_ff == ST_OK);
      sts.last        = last_ff;
      sts.dom_err     = dom_ff;
      sts.search_done = found_ff;
      sts.res_ok      = (final_st == ST_OK);
   end

   assign rsp_table_value = signed'(val_ff);
   assign rsp_status      = st_ff;
   assign rsp_flat_index  = 12'(idx_ff);
endmodule

### rtl/core/nearest_grid_table_lookup_core.sv
// ----------------------------------------------------------------------------
// nearest_grid_table_lookup_core
// Nearest-neighbor lookup of a tabulated function on a rectilinear grid.
//
//   channel | direction | handshake
//   req     | in        | req_valid / req_stall
//   rsp     | out       | rsp_valid / rsp_stall
//   csr     | in        | APB write/read, pready high
//
// A query coordinate is scanned over the grid RAM with its registered read up
// to the first grid point above it, so its time grows with the index k of
// that point; one out of domain ends after the domain check, and one counted
// without evaluation skips the scan. A final coordinate adds the table read
// and result, with no table read on error, plus any result stall.
// Reset is synchronous and clears control state and the query state.
// The block takes one item at a time; a stalled result holds until transferred.
// ----------------------------------------------------------------------------
module nearest_grid_table_lookup_core #(
   parameter int MAX_DIMS    = 4,
   parameter int GRID_DEPTH  = 256,
   parameter int TABLE_DEPTH = 4096,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [1:0]         req_dim_select,
   input  logic [11:0]        req_position,
   input  logic signed [31:0] req_data_value,
   input  logic               req_last_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_table_value,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_flat_index,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import ngtl_pkg::*;

   logic [2:0] dims_ff;
   logic [8:0] size_ff [4];
   logic       csr_wr;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 3'd1;
         for (int i = 0; i < 4; i++) size_ff[i] <= 9'd1;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_DIMS:  dims_ff    <= csr_pwdata[2:0];
            REG_SIZE0: size_ff[0] <= csr_pwdata[8:0];
            REG_SIZE1: size_ff[1] <= csr_pwdata[8:0];
            REG_SIZE2: size_ff[2] <= csr_pwdata[8:0];
            REG_SIZE3: size_ff[3] <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DIMS:  csr_prdata = {29'd0, dims_ff};
         REG_SIZE0: csr_prdata = {23'd0, size_ff[0]};
         REG_SIZE1: csr_prdata = {23'd0, size_ff[1]};
         REG_SIZE2: csr_prdata = {23'd0, size_ff[2]};
         REG_SIZE3: csr_prdata = {23'd0, size_ff[3]};
         default:   csr_prdata = '0;
      endcase
   end

   ngtl_cmd_type cmd;
   ngtl_sts_type sts;

   ngtl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts)
   );

   ngtl_dp #(
      .MAX_DIMS(MAX_DIMS), .GRID_DEPTH(GRID_DEPTH),
      .TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .dims_in_use(dims_ff), .grid_size(size_ff),
      .req_operation(req_operation), .req_dim_select(req_dim_select),
      .req_position(req_position), .req_data_value(req_data_value),
      .req_last_coord(req_last_coord),
      .rsp_table_value(rsp_table_value), .rsp_status(rsp_status),
      .rsp_flat_index(rsp_flat_index)
   );

`ifndef SYNTHESIS
   // An error result never carries a nonzero index.
   a_err_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_flat_index == 12'd0))
      else $error("error result with nonzero index");
   // No item is taken while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");
`endif
endmodule
